// ----- hw/rtl/tdwf_pkg.sv -----
// shared types and constants for the token duplicate window filter
`default_nettype none

package tdwf_pkg;

    localparam int TOKEN_W = 32;
    localparam int TIME_W  = 40;
    localparam int WIN_W   = 16;

    localparam int SLOTS_DEF = 8;
    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd15000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               vld;
        logic [TOKEN_W-1:0] tok;
        logic [TIME_W-1:0]  seen;
    } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tdwf_match.sv -----
// shared compare unit: valid entry, token equality and age below the window
`default_nettype none

module tdwf_match
(
    input  var tdwf_pkg::entry_t                 entry,
    input  var logic [tdwf_pkg::TOKEN_W-1:0]     key_token,
    input  var logic [tdwf_pkg::TIME_W-1:0]      now_time,
    input  var logic [tdwf_pkg::WIN_W-1:0]       window,
    output logic                                 hit
);

    logic signed [tdwf_pkg::TIME_W:0] age;
    logic signed [tdwf_pkg::TIME_W:0] win_ext;

    assign age     = $signed({1'b0, now_time}) - $signed({1'b0, entry.seen});
    assign win_ext = $signed({{(tdwf_pkg::TIME_W + 1 - tdwf_pkg::WIN_W){1'b0}}, window});
    assign hit     = entry.vld && (entry.tok == key_token) && (age < win_ext);

endmodule

`default_nettype wire

// ----- hw/rtl/token_dedup_window_filter.sv -----
// flow: a zero token goes from acceptance straight to the done state; a fresh token runs the
// slot scan and the write state first; a duplicate skips the write, as the scan stops at the first hit
// input: a new word is taken only when the filter is back in idle; the slot scan reads one
// table entry per cycle through a single memory read port and one shared compare unit
// reset: pointers, valid bits and control clear at once, window returns to 15000 ms
`default_nettype none

module token_dedup_window_filter
#(
    parameter int SLOTS = tdwf_pkg::SLOTS_DEF
)
(
    input  var logic                            clk,
    input  var logic                            rst_n,
    input  var logic                            cfg_valid,
    output logic                                cfg_ready,
    input  var logic [tdwf_pkg::WIN_W-1:0]      cfg_data,
    input  var logic                            in_valid,
    output logic                                in_stall,
    input  var logic                            table_select,
    input  var logic [tdwf_pkg::TOKEN_W-1:0]    token,
    input  var logic [tdwf_pkg::TIME_W-1:0]     now_time,
    output logic                                out_valid,
    input  var logic                            out_stall,
    output logic                                fresh
);

    localparam int IW    = $clog2(SLOTS);
    localparam int AW    = IW + 1;
    localparam int DEPTH = 2 << IW;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    tdwf_pkg::state_t state_reg, state_next;

    logic [tdwf_pkg::WIN_W-1:0]   window_reg;
    logic [IW-1:0]                idx_reg, idx_next;
    logic                         issuing_reg, issuing_next;
    logic                         sel_reg, sel_next;
    logic [tdwf_pkg::TOKEN_W-1:0] key_reg, key_next;
    logic [tdwf_pkg::TIME_W-1:0]  now_reg, now_next;
    logic                         result_reg, result_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         fresh_reg, fresh_next;
    logic [IW-1:0]                wp_reg [2];
    logic [IW-1:0]                wp_next [2];
    logic [DEPTH-1:0]             valid_reg;
    logic                         cmp_pend_reg, cmp_last_reg;
    tdwf_pkg::entry_t             rd_entry_reg;

    logic [tdwf_pkg::TOKEN_W-1:0] tok_mem  [DEPTH];
    logic [tdwf_pkg::TIME_W-1:0]  time_mem [DEPTH];

    logic          in_accept;
    logic          out_free;
    logic          rd_en;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          hit;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign rd_en     = (state_reg == tdwf_pkg::ST_SCAN) && issuing_reg;
    assign wr_en     = (state_reg == tdwf_pkg::ST_WRITE);
    assign rd_addr   = {sel_reg, idx_reg};
    assign wr_addr   = {sel_reg, wp_reg[sel_reg]};

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != tdwf_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign fresh     = fresh_reg;

    tdwf_match u_match
    (
        .entry     (rd_entry_reg),
        .key_token (key_reg),
        .now_time  (now_reg),
        .window    (window_reg),
        .hit       (hit)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdwf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (token == '0) ? tdwf_pkg::ST_DONE : tdwf_pkg::ST_SCAN;
                end
            end
            tdwf_pkg::ST_SCAN:
            begin
                priority if (cmp_pend_reg && hit)
                begin
                    state_next = tdwf_pkg::ST_DONE;
                end
                else if (cmp_pend_reg && cmp_last_reg)
                begin
                    state_next = tdwf_pkg::ST_WRITE;
                end
                else
                begin
                    state_next = tdwf_pkg::ST_SCAN;
                end
            end
            tdwf_pkg::ST_WRITE:
            begin
                state_next = tdwf_pkg::ST_DONE;
            end
            tdwf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = tdwf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tdwf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        issuing_next   = issuing_reg;
        sel_next       = sel_reg;
        key_next       = key_reg;
        now_next       = now_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && out_stall;
        fresh_next     = fresh_reg;
        wp_next[0]     = wp_reg[0];
        wp_next[1]     = wp_reg[1];
        unique case (state_reg)
            tdwf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    sel_next     = table_select;
                    key_next     = token;
                    now_next     = now_time;
                    idx_next     = '0;
                    issuing_next = (token != '0);
                    result_next  = 1'b1;
                end
            end
            tdwf_pkg::ST_SCAN:
            begin
                if (issuing_reg)
                begin
                    idx_next = IW'(idx_reg + 1'b1);
                    if (idx_reg == LAST)
                    begin
                        issuing_next = 1'b0;
                    end
                end
                if (cmp_pend_reg && hit)
                begin
                    result_next  = 1'b0;
                    issuing_next = 1'b0;
                end
            end
            tdwf_pkg::ST_WRITE:
            begin
                wp_next[sel_reg] = (wp_reg[sel_reg] == LAST) ? '0
                                 : IW'(wp_reg[sel_reg] + 1'b1);
            end
            tdwf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fresh_next     = result_reg;
                end
            end
            default:
            begin
                issuing_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tdwf_pkg::ST_IDLE;
            window_reg    <= tdwf_pkg::WINDOW_RESET;
            idx_reg       <= '0;
            issuing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            wp_reg[0]     <= '0;
            wp_reg[1]     <= '0;
            valid_reg     <= '0;
            cmp_pend_reg  <= 1'b0;
            cmp_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            issuing_reg   <= issuing_next;
            out_valid_reg <= out_valid_next;
            wp_reg[0]     <= wp_next[0];
            wp_reg[1]     <= wp_next[1];
            cmp_pend_reg  <= rd_en;
            cmp_last_reg  <= rd_en && (idx_reg == LAST);
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg    <= sel_next;
        key_reg    <= key_next;
        now_reg    <= now_next;
        result_reg <= result_next;
        fresh_reg  <= fresh_next;
    end

    // slot tables, one read and one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tok_mem[wr_addr]  <= key_reg;
            time_mem[wr_addr] <= now_reg;
        end
        if (rd_en)
        begin
            rd_entry_reg.vld  <= valid_reg[rd_addr];
            rd_entry_reg.tok  <= tok_mem[rd_addr];
            rd_entry_reg.seen <= time_mem[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != tdwf_pkg::ST_IDLE))
        else $error("accepted word left the filter idle");

    a_no_zero_store: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tdwf_pkg::ST_WRITE) |-> (key_reg != '0) && result_reg)
        else $error("zero or duplicate token written to table");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tdwf_pkg::ST_DONE))
        else $error("output word raised outside done state");
`endif

endmodule

`default_nettype wire
